// ----- rtl/uest_pkg.sv -----
// Package for the USB endpoint slot table: item types, codes and controller links.
`default_nettype none
package uest_pkg;

    localparam int EP_SLOTS_DEF   = 8;
    localparam int DESC_SLOTS_DEF = 16;

    localparam int OUT_SLOT_W = 3;
    localparam int OUT_DESC_W = 4;
    localparam int LEN_W      = 15;

    // opcodes
    localparam logic [2:0] OP_OPEN     = 3'd0;
    localparam logic [2:0] OP_CLOSE    = 3'd1;
    localparam logic [2:0] OP_START    = 3'd2;
    localparam logic [2:0] OP_SETADDR  = 3'd3;
    localparam logic [2:0] OP_COMPLETE = 3'd4;
    localparam logic [2:0] OP_QUERY    = 3'd5;

    // result status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOTFOUND = 3'd1;
    localparam logic [2:0] ST_NOFREE   = 3'd2;
    localparam logic [2:0] ST_BADSPEED = 3'd3;
    localparam logic [2:0] ST_BUSY     = 3'd4;
    localparam logic [2:0] ST_NOTPEND  = 3'd5;

    localparam logic [1:0] SPEED_UNDEF = 2'd0;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [6:0]       dev_addr;
        logic [7:0]       ep_num;
        logic [1:0]       dev_speed;
        logic [LEN_W-1:0] tx_length;
        logic [LEN_W-1:0] remaining_bytes;
    } t_in;

    typedef struct packed {
        logic [2:0]            status;
        logic [OUT_SLOT_W-1:0] slot;
        logic [OUT_DESC_W-1:0] main_desc;
        logic [OUT_DESC_W-1:0] setup_desc;
        logic [OUT_DESC_W-1:0] data_desc;
        logic [LEN_W-1:0]      actual_length;
    } t_out;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic search;
        logic alloc;
        logic exec;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_open;
        logic alloc_ok;
        logic alloc_last;
    } t_stat;

endpackage
`default_nettype wire

// ----- rtl/uest_ctrl.sv -----
// Sequencer for the slot table: capture, search, descriptor allocation, execute.
`default_nettype none
module uest_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire uest_pkg::t_stat i_stat,
    output uest_pkg::t_cmd      o_cmd
);
    import uest_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_ALLOC  = 2'd2;
    localparam logic [1:0] S_EXEC   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_SEARCH;
                end
            end
            S_SEARCH: begin
                o_cmd.search = 1'b1;
                n_state      = i_stat.is_open ? S_ALLOC : S_EXEC;
            end
            S_ALLOC: begin
                // one descriptor per cycle; stop early when the pool runs dry
                o_cmd.alloc = 1'b1;
                if (!i_stat.alloc_ok || i_stat.alloc_last) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

// ----- rtl/uest_dp.sv -----
// Datapath: endpoint entries, descriptor pool, lookup, allocation and result register.
`default_nettype none
module uest_dp #(
    parameter int ENDPOINT_SLOTS = uest_pkg::EP_SLOTS_DEF,
    parameter int DESC_SLOTS     = uest_pkg::DESC_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire uest_pkg::t_in  i_item,
    input  wire uest_pkg::t_cmd i_cmd,
    output uest_pkg::t_stat     o_stat,
    output logic                o_done,
    output uest_pkg::t_out      o_result
);
    import uest_pkg::*;

    localparam int SW = (ENDPOINT_SLOTS > 1) ? $clog2(ENDPOINT_SLOTS) : 1;
    localparam int DW = $clog2(DESC_SLOTS);

    // captured item
    t_in r_item;

    // entry table
    logic [ENDPOINT_SLOTS-1:0] r_valid;
    logic [ENDPOINT_SLOTS-1:0] r_pend;
    logic [6:0]                r_dev   [ENDPOINT_SLOTS];
    logic [7:0]                r_ep    [ENDPOINT_SLOTS];
    logic [DW-1:0]             r_main  [ENDPOINT_SLOTS];
    logic [DW-1:0]             r_setup [ENDPOINT_SLOTS];
    logic [DW-1:0]             r_data  [ENDPOINT_SLOTS];
    logic [LEN_W-1:0]          r_len   [ENDPOINT_SLOTS];
    logic [DESC_SLOTS-1:0]     r_desc_used;

    // per-item working registers
    logic                  r_found;
    logic [SW-1:0]         r_hit;
    logic [SW-1:0]         r_free;
    logic                  r_fail;
    logic [DESC_SLOTS-1:0] r_used_tmp;
    logic [DW-1:0]         r_d [3];
    logic [1:0]            r_cnt;

    logic r_done;
    t_out r_res;
    logic n_done;
    t_out n_res;

    // search logic
    logic [6:0]    key_dev;
    logic [7:0]    key_ep;
    logic          hit_any;
    logic [SW-1:0] hit_idx;
    logic          free_any;
    logic [SW-1:0] free_idx;
    logic          desc_any;
    logic [DW-1:0] desc_idx;
    logic          ep0;

    assign key_dev = (r_item.opcode == OP_SETADDR) ? 7'd0 : r_item.dev_addr;
    assign key_ep  = (r_item.opcode == OP_SETADDR) ? 8'd0 : r_item.ep_num;
    assign ep0     = (r_item.ep_num == 8'd0);

    // priority encoders, lowest index wins
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENDPOINT_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_dev[i] == key_dev && r_ep[i] == key_ep) begin
                hit_any = 1'b1;
                hit_idx = SW'(i);
            end
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        desc_any = 1'b0;
        desc_idx = '0;
        for (int i = DESC_SLOTS - 1; i >= 0; i--) begin
            if (!r_used_tmp[i]) begin
                desc_any = 1'b1;
                desc_idx = DW'(i);
            end
        end
    end

    assign o_stat.is_open    = (r_item.opcode == OP_OPEN);
    assign o_stat.alloc_ok   = !r_fail && desc_any;
    assign o_stat.alloc_last = (r_cnt == (ep0 ? 2'd2 : 2'd0));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.search) begin
            r_found    <= hit_any;
            r_hit      <= hit_idx;
            r_free     <= free_idx;
            r_fail     <= !free_any;
            r_used_tmp <= r_desc_used;
            r_cnt      <= 2'd0;
            r_d[0]     <= '0;
            r_d[1]     <= '0;
            r_d[2]     <= '0;
        end
        if (i_cmd.alloc) begin
            if (!r_fail && desc_any) begin
                r_d[r_cnt]           <= desc_idx;
                r_used_tmp[desc_idx] <= 1'b1;
                r_cnt                <= r_cnt + 2'd1;
            end else begin
                r_fail <= 1'b1;
            end
        end
    end

    // descriptors released by close
    logic [DESC_SLOTS-1:0] free_mask;
    logic                  open_ok;
    logic [LEN_W-1:0]      hit_len;

    assign hit_len   = r_len[r_hit];
    assign open_ok   = !r_fail && (r_item.dev_speed != SPEED_UNDEF);
    assign free_mask = (DESC_SLOTS'(1) << r_main[r_hit])
                     | (ep0 ? ((DESC_SLOTS'(1) << r_setup[r_hit])
                             | (DESC_SLOTS'(1) << r_data[r_hit])) : '0);

    // control state of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_pend      <= '0;
            r_desc_used <= '0;
        end else if (i_cmd.exec) begin
            case (r_item.opcode)
                OP_OPEN: begin
                    if (open_ok) begin
                        r_valid[r_free] <= 1'b1;
                        r_pend[r_free]  <= 1'b0;
                        r_desc_used     <= r_used_tmp;
                    end
                end
                OP_CLOSE: begin
                    if (r_found) begin
                        r_valid[r_hit] <= 1'b0;
                        r_pend[r_hit]  <= 1'b0;
                        r_desc_used    <= r_desc_used & ~free_mask;
                    end
                end
                OP_START: begin
                    if (r_found) begin
                        r_pend[r_hit] <= 1'b1;
                    end
                end
                OP_COMPLETE: begin
                    if (r_found) begin
                        r_pend[r_hit] <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            case (r_item.opcode)
                OP_OPEN: begin
                    if (open_ok) begin
                        r_dev[r_free]   <= r_item.dev_addr;
                        r_ep[r_free]    <= r_item.ep_num;
                        r_main[r_free]  <= r_d[0];
                        r_setup[r_free] <= r_d[1];
                        r_data[r_free]  <= r_d[2];
                        r_len[r_free]   <= '0;
                    end
                end
                OP_START: begin
                    if (r_found) begin
                        r_len[r_hit] <= r_item.tx_length;
                    end
                end
                OP_SETADDR: begin
                    if (r_found) begin
                        r_dev[r_hit] <= r_item.dev_addr;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result beat
    always_comb begin
        n_done = i_cmd.exec;
        n_res  = '0;
        case (r_item.opcode)
            OP_OPEN: begin
                if (r_fail) begin
                    n_res.status = ST_NOFREE;
                end else if (r_item.dev_speed == SPEED_UNDEF) begin
                    n_res.status = ST_BADSPEED;
                end else begin
                    n_res.slot       = OUT_SLOT_W'(r_free);
                    n_res.main_desc  = OUT_DESC_W'(r_d[0]);
                    n_res.setup_desc = OUT_DESC_W'(r_d[1]);
                    n_res.data_desc  = OUT_DESC_W'(r_d[2]);
                end
            end
            OP_CLOSE, OP_START, OP_SETADDR, OP_COMPLETE, OP_QUERY: begin
                if (!r_found) begin
                    n_res.status = ST_NOTFOUND;
                end else begin
                    n_res.slot       = OUT_SLOT_W'(r_hit);
                    n_res.main_desc  = OUT_DESC_W'(r_main[r_hit]);
                    n_res.setup_desc = OUT_DESC_W'(r_setup[r_hit]);
                    n_res.data_desc  = OUT_DESC_W'(r_data[r_hit]);
                    if (r_item.opcode == OP_COMPLETE) begin
                        if (!r_pend[r_hit]) begin
                            n_res.status = ST_NOTPEND;
                        end else if (hit_len > r_item.remaining_bytes) begin
                            n_res.actual_length = hit_len - r_item.remaining_bytes;
                        end
                    end else if (r_item.opcode == OP_QUERY && r_pend[r_hit]) begin
                        n_res.status = ST_BUSY;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule
`default_nettype wire

// ----- rtl/usb_endpoint_slot_table_top.sv -----
// Top level of the USB endpoint slot table: sequencer plus table datapath.
//
// Commands enter on i_cmd with start; a command is taken at a clock edge where
// start is high and busy is low. busy stays high while the command is worked on.
// Each command gives one result beat on o_result, shown for exactly one cycle
// with o_done high; the receiver cannot hold it off, so it must take it then.
// Steps, from the accepting edge: the command is captured into the search
// state; key lookup and free-slot search; then, for open only, allocation,
// which draws one descriptor per cycle (one, or three for endpoint 0) from the
// pool's priority encoder; then the execute cycle, from which o_done and the
// result are registered. An open that finds no endpoint slot leaves allocation
// after a failed draw, and one that runs the pool dry stops after the failed
// draw. busy falls in the same cycle as o_done rises, so the next command can
// be taken at the edge that ends the result beat.
// Synchronous reset empties the table, frees every descriptor, clears all
// pending bits and drops any command in flight without a result.
`default_nettype none
module usb_endpoint_slot_table_top #(
    parameter int ENDPOINT_SLOTS = uest_pkg::EP_SLOTS_DEF,
    parameter int DESC_SLOTS     = uest_pkg::DESC_SLOTS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire uest_pkg::t_in i_cmd,
    output logic               o_done,
    output uest_pkg::t_out     o_result
);
    import uest_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    uest_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    uest_dp #(
        .ENDPOINT_SLOTS (ENDPOINT_SLOTS),
        .DESC_SLOTS     (DESC_SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_cmd),
        .i_cmd    (w_cmd),
        .o_stat   (w_stat),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_exec_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.exec |=> o_done)
        else $error("execute cycle not followed by a result beat");

    a_done_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(w_cmd.exec))
        else $error("result beat without an execute cycle");

    a_alloc_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.alloc |-> w_stat.is_open)
        else $error("descriptor allocation for a command other than open");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_done))
        else $error("accepted command did not raise busy");

endmodule
`default_nettype wire
